FILE: design/pbr_pkg.sv
// Shared types, constants and register codes for the patch budget resize planner.
package pbr_pkg;

	localparam int FRAC_W     = 24;
	localparam int CELLS      = 24;
	localparam int REM_W      = 32;
	localparam int ROOT_REM_W = 26;
	localparam int RAD_W      = 2 * CELLS;
	localparam int ASPECT_MAX = 200;

	typedef enum logic [2:0] {
		CFG_PATCH_EDGE   = 3'd0,
		CFG_MERGE_KERNEL = 3'd1,
		CFG_IMAGE_LIMIT  = 3'd2,
		CFG_FRAME_LIMIT  = 3'd3,
		CFG_VIDEO_LIMIT  = 3'd4,
		CFG_SIDE_LIMIT   = 3'd5,
		CFG_FIXED_TOKENS = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ASPECT = 2'd1,
		STAT_ROWS   = 2'd2,
		STAT_COLS   = 2'd3
	} status_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [CELLS-1:0] nq;
		logic [REM_W-1:0] den;
	} pbr_div_t;

	typedef struct packed {
		logic [ROOT_REM_W-1:0] rem;
		logic [CELLS-1:0]      root;
		logic [RAD_W-1:0]      x;
	} pbr_sqrt_t;

	typedef struct packed {
		logic             vld;
		logic             aspect;
		logic [15:0]      w;
		logic [15:0]      h;
		logic [15:0]      kept;
		logic [17:0]      side;
		logic [15:0]      limit;
		logic             usev;
		logic             swv;
		logic             shv;
		logic             rootuse;
		logic [CELLS-1:0] qhi;
		logic [15:0]      nw;
		logic [15:0]      nh;
	} pbr_side_t;

	typedef struct packed {
		logic [15:0] frames_kept;
		logic [20:0] tok_count;
		logic [8:0]  pad_bottom;
		logic [8:0]  pad_right;
		logic [15:0] out_height;
		logic [15:0] out_width;
		status_t     status;
	} pbr_out_t;

endpackage

FILE: design/pbr_div_cell.sv
// One restoring division step: one quotient bit per beat.
module pbr_div_cell import pbr_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  pbr_div_t d_i,
	output pbr_div_t d_o
);

	logic [REM_W:0] t;
	logic           ge;
	logic [REM_W:0] diff;

	always_comb begin
		t    = {d_i.rem, d_i.nq[CELLS-1]};
		ge   = t >= {1'b0, d_i.den};
		diff = t - {1'b0, d_i.den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.rem <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
			d_o.nq  <= {d_i.nq[CELLS-2:0], ge};
			d_o.den <= d_i.den;
		end
	end

endmodule

FILE: design/pbr_div_chain.sv
// Row of division cells giving a full quotient word.
module pbr_div_chain import pbr_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  pbr_div_t d_i,
	output pbr_div_t d_o
);

	pbr_div_t link [CELLS+1];

	assign link[0] = d_i;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		pbr_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d_i (link[i]),
			.d_o (link[i+1])
		);
	end

	assign d_o = link[CELLS];

endmodule

FILE: design/pbr_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per beat.
module pbr_sqrt_cell import pbr_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  pbr_sqrt_t d_i,
	output pbr_sqrt_t d_o
);

	logic [ROOT_REM_W+1:0] t;
	logic [ROOT_REM_W+1:0] trial;
	logic                  ge;
	logic [ROOT_REM_W+1:0] diff;

	always_comb begin
		t     = {d_i.rem, d_i.x[RAD_W-1:RAD_W-2]};
		trial = {2'b00, d_i.root, 2'b01};
		ge    = t >= trial;
		diff  = t - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.rem  <= ge ? diff[ROOT_REM_W-1:0] : t[ROOT_REM_W-1:0];
			d_o.root <= {d_i.root[CELLS-2:0], ge};
			d_o.x    <= {d_i.x[RAD_W-3:0], 2'b00};
		end
	end

endmodule

FILE: design/pbr_side_line.sv
// Row of item-record registers that runs beside a row of arithmetic cells.
module pbr_side_line import pbr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  pbr_side_t d_i,
	output pbr_side_t d_o
);

	pbr_side_t stage_q [CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) stage_q[i] <= '0;
		end else if (en) begin
			stage_q[0] <= d_i;
			for (int i = 1; i < CELLS; i++) stage_q[i] <= stage_q[i-1];
		end
	end

	assign d_o = stage_q[CELLS-1];

endmodule

FILE: design/patch_budget_resize_planner.sv
// Top level of the patch budget resize planner.
//
// Input stream: one beat per image or video chunk. s_tuser carries the kind
// (0 still image, 1 video); s_tdata carries width, height and frame count.
// Output stream: one beat per input beat, in order. m_tuser carries the
// status; m_tdata carries the resized size, padding, token count and the
// frames kept. A nonzero status zeroes every field of m_tdata.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// write only while no beat is in flight.
// The depth from input beat to m_tvalid is set by the rows of
// division and square root cells (24 cells each, one result bit per cell).
// Throughput: one beat per cycle; every cell row advances once per cycle.
// A two-entry output buffer holds results when m_tready is low; input is
// taken as long as that buffer is not full, so a waiting result does not
// stop intake. When the buffer fills, the whole row of cells holds.
// Reset empties the pipeline and the buffer and loads the register defaults.
module patch_budget_resize_planner import pbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // src_width, src_height, frame_count
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // out_width, out_height, pad_right, pad_bottom,
	                              // tokens per frame, frames kept, zero fill
	output logic [1:0]  m_tuser,  // status
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wdata
);

	logic [6:0]  pe_q;
	logic [3:0]  mk_q;
	logic [15:0] ipl_q;
	logic [15:0] fpl_q;
	logic [19:0] vpl_q;
	logic [10:0] spl_q;
	logic [16:0] fix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_q  <= 7'd14;
			mk_q  <= 4'd2;
			ipl_q <= 16'd16384;
			fpl_q <= '0;
			vpl_q <= '0;
			spl_q <= 11'd512;
			fix_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PATCH_EDGE:   pe_q  <= cfg_wdata[6:0];
				CFG_MERGE_KERNEL: mk_q  <= cfg_wdata[3:0];
				CFG_IMAGE_LIMIT:  ipl_q <= cfg_wdata[15:0];
				CFG_FRAME_LIMIT:  fpl_q <= cfg_wdata[15:0];
				CFG_VIDEO_LIMIT:  vpl_q <= cfg_wdata;
				CFG_SIDE_LIMIT:   spl_q <= cfg_wdata[10:0];
				CFG_FIXED_TOKENS: fix_q <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	logic [6:0]  p;
	logic [3:0]  m;
	logic [10:0] factor;

	always_comb begin
		p      = (pe_q == '0) ? 7'd1 : pe_q;
		m      = (mk_q == '0) ? 4'd1 : mk_q;
		factor = 11'(m * p);
	end

	logic     adv;
	logic [1:0] cnt_q;

	assign adv      = cnt_q != 2'd2;
	assign s_tready = adv;

	// input stage
	pbr_side_t   side_in;
	logic [15:0] w_in, h_in, fc_in, big, small_side;

	always_comb begin
		w_in       = s_tdata[15:0];
		h_in       = s_tdata[31:16];
		fc_in      = s_tdata[47:32];
		big        = (w_in > h_in) ? w_in : h_in;
		small_side = (w_in > h_in) ? h_in : w_in;
		side_in         = '0;
		side_in.vld     = s_tvalid;
		side_in.w       = w_in;
		side_in.h       = h_in;
		side_in.aspect  = {8'd0, big} > 24'(small_side * ASPECT_MAX);
		side_in.kept    = (s_tuser && fc_in != '0) ? fc_in : 16'd1;
		side_in.side    = 18'(spl_q * p);
		side_in.limit   = (s_tuser && fpl_q != '0) ? fpl_q : ipl_q;
		side_in.usev    = s_tuser && vpl_q != '0;
		side_in.swv     = w_in != '0 && side_in.side < {2'b00, w_in};
		side_in.shv     = h_in != '0 && side_in.side < {2'b00, h_in};
	end

	pbr_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s1 <= '0;
		else if (adv) side_s1 <= side_in;
	end

	// first division row: per-frame budget, patch grid, side terms
	pbr_div_t per_i, a_i, b_i, sw_i, sh_i;
	pbr_div_t per_o, a_o, b_o, sw_o, sh_o;
	pbr_side_t side_g1;

	always_comb begin
		per_i.rem = '0;
		per_i.nq  = {2'b00, 22'({1'b0, vpl_q, 1'b0} + {6'd0, side_s1.kept})};
		per_i.den = {15'd0, side_s1.kept, 1'b0};
		a_i.rem   = '0;
		a_i.nq    = {8'd0, side_s1.w};
		a_i.den   = {25'd0, p};
		b_i.rem   = '0;
		b_i.nq    = {8'd0, side_s1.h};
		b_i.den   = {25'd0, p};
		sw_i.rem  = {14'd0, side_s1.side};
		sw_i.nq   = '0;
		sw_i.den  = {16'd0, side_s1.w};
		sh_i.rem  = {14'd0, side_s1.side};
		sh_i.nq   = '0;
		sh_i.den  = {16'd0, side_s1.h};
	end

	pbr_div_chain u_per (.clk(clk), .en(adv), .d_i(per_i), .d_o(per_o));
	pbr_div_chain u_a   (.clk(clk), .en(adv), .d_i(a_i),   .d_o(a_o));
	pbr_div_chain u_b   (.clk(clk), .en(adv), .d_i(b_i),   .d_o(b_o));
	pbr_div_chain u_sw  (.clk(clk), .en(adv), .d_i(sw_i),  .d_o(sw_o));
	pbr_div_chain u_sh  (.clk(clk), .en(adv), .d_i(sh_i),  .d_o(sh_o));
	pbr_side_line u_line1 (.clk(clk), .arst_n(arst_n), .en(adv), .d_i(side_s1), .d_o(side_g1));

	// budget and grid
	logic [15:0] ga, gb;
	pbr_side_t   side_s2_d;
	logic [CELLS-1:0] sw_s2, sh_s2;
	pbr_side_t   side_s2;
	logic [31:0] grid_s2;

	always_comb begin
		ga = (a_o.nq[15:0] == '0) ? 16'd1 : a_o.nq[15:0];
		gb = (b_o.nq[15:0] == '0) ? 16'd1 : b_o.nq[15:0];
		side_s2_d = side_g1;
		if (side_g1.usev && per_o.nq < {8'd0, side_g1.limit})
			side_s2_d.limit = per_o.nq[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s2 <= '0;
		else if (adv) side_s2 <= side_s2_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grid_s2 <= ga * gb;
			sw_s2   <= sw_o.nq;
			sh_s2   <= sh_o.nq;
		end
	end

	// side terms ride with the record through the root rows
	pbr_side_t side_r0;
	logic [CELLS-1:0] sw_r [3*CELLS];
	logic [CELLS-1:0] sh_r [3*CELLS];

	always_ff @(posedge clk) begin
		if (adv) begin
			sw_r[0] <= sw_s2;
			sh_r[0] <= sh_s2;
			for (int i = 1; i < 3 * CELLS; i++) begin
				sw_r[i] <= sw_r[i-1];
				sh_r[i] <= sh_r[i-1];
			end
		end
	end

	// budget over grid, 48 quotient bits in two rows
	pbr_div_t qa_i, qa_o, qb_i, qb_o;
	pbr_side_t side_ga, side_gb_i, side_gb;

	always_comb begin
		qa_i.rem = {16'd0, side_s2.limit};
		qa_i.nq  = '0;
		qa_i.den = grid_s2;
		side_r0  = side_s2;
		side_r0.rootuse = {16'd0, side_s2.limit} < grid_s2;
	end

	pbr_div_chain u_qa (.clk(clk), .en(adv), .d_i(qa_i), .d_o(qa_o));
	pbr_side_line u_line2 (.clk(clk), .arst_n(arst_n), .en(adv), .d_i(side_r0), .d_o(side_ga));

	always_comb begin
		qb_i.rem      = qa_o.rem;
		qb_i.nq       = '0;
		qb_i.den      = qa_o.den;
		side_gb_i     = side_ga;
		side_gb_i.qhi = qa_o.nq;
	end

	pbr_div_chain u_qb (.clk(clk), .en(adv), .d_i(qb_i), .d_o(qb_o));
	pbr_side_line u_line3 (.clk(clk), .arst_n(arst_n), .en(adv), .d_i(side_gb_i), .d_o(side_gb));

	// square root of the quotient
	pbr_sqrt_t rt [CELLS+1];
	pbr_side_t side_rt;

	always_comb begin
		rt[0].rem  = '0;
		rt[0].root = '0;
		rt[0].x    = {side_gb.qhi, qb_o.nq};
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_root
		pbr_sqrt_cell u_cell (.clk(clk), .en(adv), .d_i(rt[i]), .d_o(rt[i+1]));
	end

	pbr_side_line u_line4 (.clk(clk), .arst_n(arst_n), .en(adv), .d_i(side_gb), .d_o(side_rt));

	// scale
	logic [FRAC_W:0] scale_d, scale_s3;
	pbr_side_t side_s3;
	logic [CELLS-1:0] sw_t, sh_t;

	always_comb begin
		sw_t    = sw_r[3*CELLS-1];
		sh_t    = sh_r[3*CELLS-1];
		scale_d = {1'b1, {FRAC_W{1'b0}}};
		if (side_rt.rootuse && {1'b0, rt[CELLS].root} < scale_d)
			scale_d = {1'b0, rt[CELLS].root};
		if (side_rt.swv && {1'b0, sw_t} < scale_d)
			scale_d = {1'b0, sw_t};
		if (side_rt.shv && {1'b0, sh_t} < scale_d)
			scale_d = {1'b0, sh_t};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s3 <= '0;
		else if (adv) side_s3 <= side_rt;
	end

	always_ff @(posedge clk) begin
		if (adv) scale_s3 <= scale_d;
	end

	// resized size
	logic [FRAC_W+16:0] pw_prod, ph_prod;
	logic [15:0] nw0_s4, nh0_s4;
	pbr_side_t side_s4;

	always_comb begin
		pw_prod = side_s3.w * scale_s3;
		ph_prod = side_s3.h * scale_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s4 <= '0;
		else if (adv) side_s4 <= side_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nw0_s4 <= pw_prod[FRAC_W+15:FRAC_W];
			nh0_s4 <= ph_prod[FRAC_W+15:FRAC_W];
		end
	end

	pbr_side_t side_s5_d, side_s5;

	always_comb begin
		side_s5_d    = side_s4;
		side_s5_d.nw = (nw0_s4 == '0) ? 16'd1 : nw0_s4;
		side_s5_d.nh = (nh0_s4 == '0) ? 16'd1 : nh0_s4;
		if ({2'b00, side_s5_d.nw} > side_s4.side) side_s5_d.nw = side_s4.side[15:0];
		if ({2'b00, side_s5_d.nh} > side_s4.side) side_s5_d.nh = side_s4.side[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s5 <= '0;
		else if (adv) side_s5 <= side_s5_d;
	end

	// token grid
	pbr_div_t cw_i, cw_o, ch_i, ch_o;
	pbr_side_t side_g3;

	always_comb begin
		cw_i.rem = '0;
		cw_i.nq  = {8'd0, side_s5.nw};
		cw_i.den = {21'd0, factor};
		ch_i.rem = '0;
		ch_i.nq  = {8'd0, side_s5.nh};
		ch_i.den = {21'd0, factor};
	end

	pbr_div_chain u_cw (.clk(clk), .en(adv), .d_i(cw_i), .d_o(cw_o));
	pbr_div_chain u_ch (.clk(clk), .en(adv), .d_i(ch_i), .d_o(ch_o));
	pbr_side_line u_line5 (.clk(clk), .arst_n(arst_n), .en(adv), .d_i(side_s5), .d_o(side_g3));

	logic [10:0] rw, rh;
	pbr_side_t   side_s6;
	logic [10:0] pw_s6, ph_s6;
	logic [16:0] cols_s6, rows_s6;

	always_comb begin
		rw = cw_o.rem[10:0];
		rh = ch_o.rem[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s6 <= '0;
		else if (adv) side_s6 <= side_g3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_s6   <= (rw == '0) ? 11'd0 : factor - rw;
			ph_s6   <= (rh == '0) ? 11'd0 : factor - rh;
			cols_s6 <= {1'b0, cw_o.nq[15:0]} + {16'd0, rw != '0};
			rows_s6 <= {1'b0, ch_o.nq[15:0]} + {16'd0, rh != '0};
		end
	end

	// result
	pbr_out_t    res;
	logic [20:0] rows_m, cols_m;
	logic [33:0] grid_tok;

	always_comb begin
		rows_m   = 21'(rows_s6 * m);
		cols_m   = 21'(cols_s6 * m);
		grid_tok = rows_s6 * cols_s6;
		res      = '0;
		if (side_s6.aspect) begin
			res.status = STAT_ASPECT;
		end else if (!fix_q[16] || (rows_m <= {10'd0, spl_q} && cols_m <= {10'd0, spl_q})) begin
			res.status      = STAT_OK;
			res.out_width   = side_s6.nw;
			res.out_height  = side_s6.nh;
			res.pad_right   = pw_s6[8:0];
			res.pad_bottom  = ph_s6[8:0];
			res.tok_count   = fix_q[16] ? grid_tok[20:0] : {5'd0, fix_q[15:0]};
			res.frames_kept = side_s6.kept;
		end else if (rows_m > {10'd0, spl_q}) begin
			res.status = STAT_ROWS;
		end else begin
			res.status = STAT_COLS;
		end
	end

	// output buffer
	pbr_out_t ent_q [2];
	logic     push, pop, wr_idx;

	assign push   = adv && side_s6.vld;
	assign pop    = m_tvalid && m_tready;
	assign wr_idx = (cnt_q == 2'd1) && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
	end

	always_ff @(posedge clk) begin
		if (push && !wr_idx) ent_q[0] <= res;
		else if (pop) ent_q[0] <= ent_q[1];
		if (push && wr_idx) ent_q[1] <= res;
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tuser  = ent_q[0].status;
	assign m_tdata  = {1'b0, ent_q[0].frames_kept, ent_q[0].tok_count,
		ent_q[0].pad_bottom, ent_q[0].pad_right, ent_q[0].out_height, ent_q[0].out_width};

endmodule

FILE: design/pbr_checker.sv
// Port checks for the patch budget resize planner, bound to the top level.
module pbr_checker import pbr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("fault beat carries nonzero fields");

	a_frames: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK |-> m_tdata[86:71] != '0 && !m_tdata[87])
		else $error("ok beat with no frames kept");

endmodule

bind patch_budget_resize_planner pbr_checker u_pbr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
